@@ sv/sips_pkg.sv @@
// Package for the sorted index pair set block.
// Holds operation, status and cell control codes used by the cell and the top level.
// Depends on nothing.
package sips_pkg;

  localparam int FUNC_W = 2;
  localparam int STAT_W = 3;
  localparam int PLANE_IDX_W = 11;
  localparam int VAR_IDX_W = 5;
  localparam int POS_W = 5;
  localparam int PLIM_W = 10;
  localparam int DIM_W = 5;

  typedef logic [FUNC_W-1:0] func_t;
  localparam func_t FUNC_INSERT = 2'd0;
  localparam func_t FUNC_DELETE = 2'd1;
  localparam func_t FUNC_CLEAR = 2'd2;

  typedef logic [STAT_W-1:0] stat_t;
  localparam stat_t STAT_SKIPPED = 3'd0;
  localparam stat_t STAT_INSERTED = 3'd1;
  localparam stat_t STAT_PRESENT = 3'd2;
  localparam stat_t STAT_REMOVED = 3'd3;
  localparam stat_t STAT_ABSENT = 3'd4;
  localparam stat_t STAT_FULL = 3'd5;
  localparam stat_t STAT_RANGE = 3'd6;

  typedef logic [1:0] cell_mode_t;
  localparam cell_mode_t MODE_HOLD = 2'd0;
  localparam cell_mode_t MODE_INS = 2'd1;
  localparam cell_mode_t MODE_DEL = 2'd2;
  localparam cell_mode_t MODE_ROT = 2'd3;

  typedef struct packed {
    cell_mode_t mode;
    logic       occupied;
  } cell_ctrl_t;

endpackage

@@ sv/sips_cell.sv @@
// One list cell of the sorted index pair set: holds one entry.
// Compares against the key, shifts with its neighbors and rotates for readout.
// Depends on sips_pkg.
module sips_cell #(
  parameter int W = 10
) (
  input  logic                 clk,
  input  sips_pkg::cell_ctrl_t ctrl,
  input  logic [W-1:0]         key,
  input  logic [W-1:0]         prev_val,
  input  logic                 prev_lt,
  input  logic [W-1:0]         next_val,
  output logic [W-1:0]         val,
  output logic                 lt,
  output logic                 eq
);

  logic [W-1:0] val_r;
  logic [W-1:0] val_nxt;

  assign val = val_r;
  assign lt = ctrl.occupied && (val_r < key);
  assign eq = ctrl.occupied && (val_r == key);

  always_comb begin
    unique case (ctrl.mode)
      sips_pkg::MODE_INS: begin
        if (lt) begin
          val_nxt = val_r;
        end else if (prev_lt) begin
          val_nxt = key;
        end else begin
          val_nxt = prev_val;
        end
      end
      sips_pkg::MODE_DEL: begin
        val_nxt = lt ? val_r : next_val;
      end
      sips_pkg::MODE_ROT: begin
        val_nxt = next_val;
      end
      default: begin
        val_nxt = val_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ sv/sorted_index_pair_set.sv @@
// Top level of the sorted index pair set: control, registers and two cell rows.
// Depends on sips_pkg and sips_cell.
//
// Usage: an operation is one transaction on start/busy with in_func,
// in_plane_index and in_var_index; it is taken when start is high and busy
// is low. Two sorted lists live in rows of cells, one entry per cell. The
// operation is applied to all cells together in S_OP, after which the rows
// rotate one cell per cycle and cell 0 is read out. Results appear on the
// out_ ports, one per cycle with out_valid high, positions 0 to the
// effective dimension, the last marked by out_last.
// After acceptance the S_OP state applies the operation and the S_DUMP state
// follows; busy stays high through both and drops once the full rotation of
// the cell rows and the last result are both done.
// The receiver cannot stall; every result is shown for exactly one cycle.
// The APB port holds plane_limit at address 0 and dimension at address 4;
// a write to either empties both lists and must be made while idle.
// Reset restores plane_limit to 1023 and dimension to 16 and empties the
// lists; no clearing pass is needed.
module sorted_index_pair_set #(
  parameter int MAX_DIM = 16,
  parameter int MAX_PLANES = 1023
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [2:0]                         paddr,
  input  logic [31:0]                        pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  logic                               start,
  output logic                               busy,
  input  logic [sips_pkg::FUNC_W-1:0]        in_func,
  input  logic [sips_pkg::PLANE_IDX_W-1:0]   in_plane_index,
  input  logic [sips_pkg::VAR_IDX_W-1:0]     in_var_index,
  output logic                               out_valid,
  output logic [sips_pkg::POS_W-1:0]         out_position,
  output logic [sips_pkg::PLANE_IDX_W-1:0]   out_plane_entry,
  output logic [sips_pkg::VAR_IDX_W-1:0]     out_var_entry,
  output logic [sips_pkg::STAT_W-1:0]        out_plane_status,
  output logic [sips_pkg::STAT_W-1:0]        out_var_status,
  output logic [sips_pkg::POS_W-1:0]         out_plane_count,
  output logic [sips_pkg::POS_W-1:0]         out_var_count,
  output logic                               out_last
);

  localparam int FW = $clog2(MAX_DIM + 1);
  localparam int DIM_CAP = (MAX_DIM > 31) ? 31 : MAX_DIM;
  localparam int PLIM_CAP = (MAX_PLANES > 1023) ? 1023 : MAX_PLANES;
  localparam int PW = sips_pkg::PLIM_W;
  localparam int VW = sips_pkg::VAR_IDX_W;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_OP = 2'd1;
  localparam logic [1:0] S_DUMP = 2'd2;

  logic [1:0]                        state_r, state_nxt;
  logic [PW-1:0]                     plim_r;
  logic [sips_pkg::DIM_W-1:0]        dim_r;
  logic [FW-1:0]                     pfill_r, pfill_nxt;
  logic [FW-1:0]                     vfill_r, vfill_nxt;
  logic [FW-1:0]                     step_r, step_nxt;
  sips_pkg::func_t                   func_r;
  logic [sips_pkg::PLANE_IDX_W-1:0]  pkey_r;
  logic [VW-1:0]                     vkey_r;
  sips_pkg::stat_t                   pstat_r, pstat_nxt;
  sips_pkg::stat_t                   vstat_r, vstat_nxt;

  logic                              out_valid_r;
  logic [sips_pkg::POS_W-1:0]        out_position_r;
  logic [sips_pkg::PLANE_IDX_W-1:0]  out_plane_entry_r;
  logic [VW-1:0]                     out_var_entry_r;
  logic                              out_last_r;

  logic [sips_pkg::DIM_W-1:0]        eff_dim;
  logic [PW-1:0]                     eff_plim;
  logic [sips_pkg::PLANE_IDX_W-1:0]  pmark;
  logic [VW:0]                       vmark;

  logic [PW-1:0]                     plane_val [MAX_DIM];
  logic [VW-1:0]                     var_val [MAX_DIM];
  logic [MAX_DIM-1:0]                plane_lt, plane_eq, var_lt, var_eq;
  sips_pkg::cell_mode_t              pmode, vmode;

  logic                              accept, cfg_wr, is_op, is_del;
  logic                              emit, rotate, done;

  assign accept = start && (state_r == S_IDLE);
  assign busy = (state_r != S_IDLE);
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;
  assign prdata = paddr[2] ? {27'd0, dim_r} : {22'd0, plim_r};

  always_comb begin
    if (dim_r == '0) begin
      eff_dim = 5'd1;
    end else if (dim_r > 5'(DIM_CAP)) begin
      eff_dim = 5'(DIM_CAP);
    end else begin
      eff_dim = dim_r;
    end
    if (plim_r == '0) begin
      eff_plim = 10'd1;
    end else if (plim_r > 10'(PLIM_CAP)) begin
      eff_plim = 10'(PLIM_CAP);
    end else begin
      eff_plim = plim_r;
    end
  end

  assign pmark = {1'b0, eff_plim} + 11'd1;
  assign vmark = {1'b0, eff_dim} + 6'd1;

  for (genvar k = 0; k < MAX_DIM; k++) begin : g_cells
    sips_pkg::cell_ctrl_t pctrl, vctrl;
    assign pctrl.mode = pmode;
    assign pctrl.occupied = (pfill_r > FW'(k));
    assign vctrl.mode = vmode;
    assign vctrl.occupied = (vfill_r > FW'(k));

    sips_cell #(.W(PW)) u_pcell (
      .clk      (clk),
      .ctrl     (pctrl),
      .key      (pkey_r[PW-1:0]),
      .prev_val (plane_val[(k + MAX_DIM - 1) % MAX_DIM]),
      .prev_lt  ((k == 0) ? 1'b1 : plane_lt[(k + MAX_DIM - 1) % MAX_DIM]),
      .next_val (plane_val[(k + 1) % MAX_DIM]),
      .val      (plane_val[k]),
      .lt       (plane_lt[k]),
      .eq       (plane_eq[k])
    );

    sips_cell #(.W(VW)) u_vcell (
      .clk      (clk),
      .ctrl     (vctrl),
      .key      (vkey_r),
      .prev_val (var_val[(k + MAX_DIM - 1) % MAX_DIM]),
      .prev_lt  ((k == 0) ? 1'b1 : var_lt[(k + MAX_DIM - 1) % MAX_DIM]),
      .next_val (var_val[(k + 1) % MAX_DIM]),
      .val      (var_val[k]),
      .lt       (var_lt[k]),
      .eq       (var_eq[k])
    );
  end

  assign is_op = (func_r == sips_pkg::FUNC_INSERT) || (func_r == sips_pkg::FUNC_DELETE);
  assign is_del = (func_r == sips_pkg::FUNC_DELETE);
  assign emit = (8'(step_r) <= 8'(eff_dim));
  assign rotate = (8'(step_r) < 8'(MAX_DIM));
  assign done = (8'(step_r) >= 8'(eff_dim)) && (8'(step_r) >= 8'(MAX_DIM - 1));

  always_comb begin
    state_nxt = state_r;
    step_nxt = step_r;
    pfill_nxt = pfill_r;
    vfill_nxt = vfill_r;
    pstat_nxt = pstat_r;
    vstat_nxt = vstat_r;
    pmode = sips_pkg::MODE_HOLD;
    vmode = sips_pkg::MODE_HOLD;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_OP;
        end
      end
      S_OP: begin
        pstat_nxt = sips_pkg::STAT_SKIPPED;
        vstat_nxt = sips_pkg::STAT_SKIPPED;
        if (is_op) begin
          if (pkey_r > pmark) begin
            pstat_nxt = sips_pkg::STAT_RANGE;
          end else if (pkey_r == pmark) begin
            pstat_nxt = sips_pkg::STAT_SKIPPED;
          end else if (is_del) begin
            pstat_nxt = (|plane_eq) ? sips_pkg::STAT_REMOVED : sips_pkg::STAT_ABSENT;
          end else if (|plane_eq) begin
            pstat_nxt = sips_pkg::STAT_PRESENT;
          end else if (8'(pfill_r) >= 8'(eff_dim)) begin
            pstat_nxt = sips_pkg::STAT_FULL;
          end else begin
            pstat_nxt = sips_pkg::STAT_INSERTED;
          end
          if ({1'b0, vkey_r} > vmark) begin
            vstat_nxt = sips_pkg::STAT_RANGE;
          end else if ({1'b0, vkey_r} == vmark) begin
            vstat_nxt = sips_pkg::STAT_SKIPPED;
          end else if (is_del) begin
            vstat_nxt = (|var_eq) ? sips_pkg::STAT_REMOVED : sips_pkg::STAT_ABSENT;
          end else if (|var_eq) begin
            vstat_nxt = sips_pkg::STAT_PRESENT;
          end else if (8'(vfill_r) >= 8'(eff_dim)) begin
            vstat_nxt = sips_pkg::STAT_FULL;
          end else begin
            vstat_nxt = sips_pkg::STAT_INSERTED;
          end
        end else if (func_r == sips_pkg::FUNC_CLEAR) begin
          pfill_nxt = '0;
          vfill_nxt = '0;
        end
        if (pstat_nxt == sips_pkg::STAT_INSERTED) begin
          pmode = sips_pkg::MODE_INS;
          pfill_nxt = pfill_r + FW'(1);
        end else if (pstat_nxt == sips_pkg::STAT_REMOVED) begin
          pmode = sips_pkg::MODE_DEL;
          pfill_nxt = pfill_r - FW'(1);
        end
        if (vstat_nxt == sips_pkg::STAT_INSERTED) begin
          vmode = sips_pkg::MODE_INS;
          vfill_nxt = vfill_r + FW'(1);
        end else if (vstat_nxt == sips_pkg::STAT_REMOVED) begin
          vmode = sips_pkg::MODE_DEL;
          vfill_nxt = vfill_r - FW'(1);
        end
        step_nxt = '0;
        state_nxt = S_DUMP;
      end
      S_DUMP: begin
        if (rotate) begin
          pmode = sips_pkg::MODE_ROT;
          vmode = sips_pkg::MODE_ROT;
        end
        step_nxt = step_r + FW'(1);
        if (done) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    if (cfg_wr) begin
      pfill_nxt = '0;
      vfill_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      plim_r <= 10'd1023;
      dim_r <= 5'd16;
      pfill_r <= '0;
      vfill_r <= '0;
      step_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      pfill_r <= pfill_nxt;
      vfill_r <= vfill_nxt;
      step_r <= step_nxt;
      out_valid_r <= (state_r == S_DUMP) && emit;
      if (cfg_wr) begin
        if (paddr[2]) begin
          dim_r <= pwdata[4:0];
        end else begin
          plim_r <= pwdata[9:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    pstat_r <= pstat_nxt;
    vstat_r <= vstat_nxt;
    if (accept) begin
      func_r <= in_func;
      pkey_r <= in_plane_index;
      vkey_r <= in_var_index;
    end
    if ((state_r == S_DUMP) && emit) begin
      out_position_r <= 5'(step_r);
      out_plane_entry_r <= (8'(step_r) < 8'(pfill_r)) ? {1'b0, plane_val[0]} : pmark;
      out_var_entry_r <= (8'(step_r) < 8'(vfill_r)) ? var_val[0] : vmark[VW-1:0];
      out_last_r <= (8'(step_r) == 8'(eff_dim));
    end
  end

  assign out_valid = out_valid_r;
  assign out_position = out_position_r;
  assign out_plane_entry = out_plane_entry_r;
  assign out_var_entry = out_var_entry_r;
  assign out_plane_status = pstat_r;
  assign out_var_status = vstat_r;
  assign out_plane_count = 5'(pfill_r);
  assign out_var_count = 5'(vfill_r);
  assign out_last = out_last_r;

endmodule

@@ sv/sips_checker.sv @@
// Port-level checker for the sorted index pair set and its bind statement.
// Depends on the sorted_index_pair_set top level.
module sips_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       start,
  input logic       busy,
  input logic       out_valid,
  input logic [4:0] out_position,
  input logic       out_last
);

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("Accepted transaction did not raise busy.");

  a_first_pos: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> (out_position == 5'd0))
    else $error("First result of a transaction is not at position zero.");

  a_pos_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_last |=> out_valid && (out_position == 5'($past(out_position) + 5'd1)))
    else $error("Results of a transaction are not consecutive.");

  a_last_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last |=> !out_valid)
    else $error("Result shown right after the last result of a transaction.");

endmodule

bind sorted_index_pair_set sips_checker u_sips_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .start        (start),
  .busy         (busy),
  .out_valid    (out_valid),
  .out_position (out_position),
  .out_last     (out_last)
);
